// File: rtl/tcw_pkg.sv
// Package for the text console cell writer: item types, command codes,
// character constants and parameter defaults. Depends on nothing.
package tcw_pkg;

  localparam int unsigned COLUMNS_DEF   = 80;
  localparam int unsigned ROWS_DEF      = 25;
  localparam int unsigned TAB_WIDTH_DEF = 4;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  localparam logic [15:0] RESET_CELL = 16'h0F20;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  char_code;
    logic [7:0]  color;
    logic [10:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [10:0] cursor_pos;
  } tcw_out_t;

  typedef enum logic [2:0] {
    OP_GLYPH,
    OP_NEWLINE,
    OP_TAB,
    OP_RETURN,
    OP_CLEAR,
    OP_READ,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  char_code;
    logic [7:0]  color;
    logic [10:0] cell_index;
  } cmd_t;

endpackage

// File: rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tcw_fifo.sv
// Small register queue with push/full and pop/empty sides.
// No dependencies.
module tcw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wptr_q + 1'b1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/tcw_front.sv
// Front end: accepts request items, decodes them into commands and queues them.
// Depends on tcw_pkg and tcw_fifo.
module tcw_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            init_busy_i,
  input  logic            push_i,
  input  tcw_pkg::tcw_in_t item_i,
  output logic            full_o,
  input  logic            cmd_pop_i,
  output tcw_pkg::cmd_t    cmd_o,
  output logic            cmd_valid_o
);
  import tcw_pkg::*;

  cmd_t cmd_in;
  logic q_full, q_empty;
  logic [$bits(cmd_t)-1:0] q_rdata;

  always_comb begin
    cmd_in.char_code  = item_i.char_code;
    cmd_in.color      = item_i.color;
    cmd_in.cell_index = item_i.cell_index;
    unique case (item_i.req_type)
      REQ_PUT: begin
        if (item_i.char_code == CH_NEWLINE) begin
          cmd_in.op = OP_NEWLINE;
        end else if (item_i.char_code == CH_TAB) begin
          cmd_in.op = OP_TAB;
        end else if (item_i.char_code == CH_RETURN) begin
          cmd_in.op = OP_RETURN;
        end else begin
          cmd_in.op = OP_GLYPH;
        end
      end
      REQ_CLEAR: cmd_in.op = OP_CLEAR;
      REQ_READ:  cmd_in.op = OP_READ;
      default:   cmd_in.op = OP_NONE;
    endcase
  end

  assign full_o = q_full || init_busy_i;

  tcw_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && !full_o),
    .wdata_i (cmd_in),
    .full_o  (q_full),
    .pop_i   (cmd_pop_i),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign cmd_o       = cmd_t'(q_rdata);
  assign cmd_valid_o = !q_empty;

endmodule

// File: rtl/tcw_back.sv
// Back end: executes commands against the screen RAM and the cursor.
// Depends on tcw_pkg and tcw_ram.
module tcw_back #(
  parameter int unsigned COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS      = tcw_pkg::ROWS_DEF,
  parameter int unsigned TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tcw_pkg::cmd_t     cmd_i,
  input  logic             cmd_valid_i,
  output logic             cmd_pop_o,
  output tcw_pkg::tcw_out_t res_o,
  output logic             res_push_o,
  input  logic             res_full_i,
  output logic             init_busy_o
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CNT_W = $clog2(CELLS + 1);
  localparam int unsigned CMP_W = (CNT_W > 11) ? CNT_W : 11;
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned PW    = $clog2(CELLS);
  localparam int unsigned TBW   = $clog2(TAB_WIDTH + 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_TAB,
    ST_SCROLL,
    ST_FILL,
    ST_READ,
    ST_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [TBW-1:0]   tab_q, tab_d;
  logic [RW-1:0]    row_q, row_d;
  logic [CW-1:0]    col_q, col_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [15:0]      data_q, data_d;
  logic [15:0]      fill_q, fill_d;

  logic [RW-1:0]    adv_row;
  logic [CW-1:0]    adv_col;
  logic [PW-1:0]    adv_pos;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [15:0]      wdata, rdata;

  always_comb begin
    if (col_q == CW'(COLUMNS - 1)) begin
      adv_col = '0;
      if (row_q == RW'(ROWS - 1)) begin
        adv_row = '0;
        adv_pos = '0;
      end else begin
        adv_row = RW'(row_q + 1'b1);
        adv_pos = PW'(pos_q + 1'b1);
      end
    end else begin
      adv_col = CW'(col_q + 1'b1);
      adv_row = row_q;
      adv_pos = PW'(pos_q + 1'b1);
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    tab_d     = tab_q;
    row_d     = row_q;
    col_d     = col_q;
    pos_d     = pos_q;
    data_d    = data_q;
    fill_d    = fill_q;
    we        = 1'b0;
    waddr     = AW'(cnt_q);
    wdata     = fill_q;
    raddr     = '0;
    cmd_pop_o = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        we    = 1'b1;
        wdata = RESET_CELL;
        if (cnt_q == CNT_W'(CELLS - 1)) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = CNT_W'(cnt_q + 1'b1);
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          data_d    = '0;
          fill_d    = {cmd_i.color, CH_SPACE};
          cnt_d     = '0;
          tab_d     = '0;
          unique case (cmd_i.op)
            OP_GLYPH: begin
              we      = 1'b1;
              waddr   = AW'(pos_q);
              wdata   = {cmd_i.color, cmd_i.char_code};
              row_d   = adv_row;
              col_d   = adv_col;
              pos_d   = adv_pos;
              state_d = ST_DONE;
            end
            OP_TAB: state_d = ST_TAB;
            OP_RETURN: begin
              col_d   = '0;
              pos_d   = PW'(pos_q - PW'(col_q));
              state_d = ST_DONE;
            end
            OP_NEWLINE: begin
              col_d = '0;
              if (row_q == RW'(ROWS - 1)) begin
                pos_d   = PW'(CELLS - COLUMNS);
                state_d = ST_SCROLL;
              end else begin
                row_d   = RW'(row_q + 1'b1);
                pos_d   = PW'(pos_q - PW'(col_q) + PW'(COLUMNS));
                state_d = ST_DONE;
              end
            end
            OP_CLEAR: state_d = ST_FILL;
            OP_READ: begin
              if (CMP_W'(cmd_i.cell_index) < CMP_W'(CELLS)) begin
                raddr   = AW'(cmd_i.cell_index);
                state_d = ST_READ;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_TAB: begin
        we    = 1'b1;
        waddr = AW'(pos_q);
        row_d = adv_row;
        col_d = adv_col;
        pos_d = adv_pos;
        tab_d = TBW'(tab_q + 1'b1);
        if (tab_q == TBW'(TAB_WIDTH - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_SCROLL: begin
        waddr = AW'(cnt_q - 1'b1);
        wdata = rdata;
        we    = (cnt_q != '0);
        if (cnt_q == CNT_W'(CELLS - COLUMNS)) begin
          state_d = ST_FILL;
        end else begin
          raddr = AW'(cnt_q + CNT_W'(COLUMNS));
          cnt_d = CNT_W'(cnt_q + 1'b1);
        end
      end
      ST_FILL: begin
        we = 1'b1;
        if (cnt_q == CNT_W'(CELLS - 1)) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = CNT_W'(cnt_q + 1'b1);
        end
      end
      ST_READ: begin
        data_d  = rdata;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!res_full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
      tab_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tab_q   <= tab_d;
      row_q   <= row_d;
      col_q   <= col_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    fill_q <= fill_d;
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign res_push_o       = (state_q == ST_DONE) && !res_full_i;
  assign res_o.read_data  = data_q;
  assign res_o.cursor_pos = 11'(pos_q);
  assign init_busy_o      = (state_q == ST_INIT);

endmodule

// File: rtl/text_console_cell_writer.sv
// Top level of the text console cell writer: front decode queue, back executor
// with screen RAM, result queue. Depends on tcw_pkg, tcw_front, tcw_back, tcw_fifo.
//
//   channel   handshake        payload
//   request   push / full      item_i   (tcw_in_t)
//   result    pop / empty      result_o (tcw_out_t)
//
// After reset the RAM is swept to blank cells, one a cycle, over all ROWS*COLUMNS
// cells (2000 by default); full stays high meanwhile. The executor runs one command
// at a time and pushes a result for each, waiting while the result queue is full.
// A tab writes TAB_WIDTH blank cells, one RAM write a cycle; a scrolling newline
// moves rows up and blanks the last row; a clear blanks all cells. Two decoded items
// queue ahead of the executor, two results behind it; each side stalls on its own.
module text_console_cell_writer #(
  parameter int unsigned COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS      = tcw_pkg::ROWS_DEF,
  parameter int unsigned TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  tcw_pkg::tcw_in_t  item_i,
  output logic             full,
  input  logic             pop,
  output tcw_pkg::tcw_out_t result_o,
  output logic             empty
);
  import tcw_pkg::*;

  cmd_t     cmd;
  logic     cmd_valid, cmd_pop;
  tcw_out_t res;
  logic     res_push, res_full, init_busy;
  logic [$bits(tcw_out_t)-1:0] res_rdata;

  tcw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_busy_i (init_busy),
    .push_i      (push),
    .item_i      (item_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid)
  );

  tcw_back #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .init_busy_o (init_busy)
  );

  tcw_fifo #(
    .WIDTH ($bits(tcw_out_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign result_o = tcw_out_t'(res_rdata);

  a_res_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_cmd_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  a_init_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> (empty && !cmd_valid && full))
    else $error("activity during screen init sweep");

endmodule
